>>> design/bobl_pkg.sv
// Package for the bounded ordered byte list: field widths, request and
// status codes, and the command and status bundles between controller and datapath.
// Depends on nothing; every other design file but bobl_ram uses it, as do the testbench files.
package bobl_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ORDERED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PREPEND   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_VALUE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DEL_HEAD  = 3'd4;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch a request and prepare the pass
    logic step;    // a step of the forward pass over the entries
    logic tail;    // final write and count update
    logic finish;  // load the response register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early;        // the request on the port is answered without a pass
    logic direct_tail;  // the request on the port only writes at the end
    logic pass_done;    // every entry has been read and handled
    logic out_free;     // the response register can take a new word
  } dp_stat_t;

  function automatic logic kind_is_insert(input logic [KIND_W-1:0] k);
    return (k == KIND_ORDERED) || (k == KIND_APPEND) || (k == KIND_PREPEND);
  endfunction

  function automatic logic kind_is_delete(input logic [KIND_W-1:0] k);
    return (k == KIND_DEL_VALUE) || (k == KIND_DEL_HEAD);
  endfunction

endpackage

>>> design/bobl_req_if.sv
// Request channel of the bounded ordered byte list: valid, ready and payload.
// Depends on bobl_pkg for the field widths.
interface bobl_req_if;
  logic                                valid;
  logic                                ready;
  logic [bobl_pkg::KIND_W-1:0]         kind;
  logic signed [bobl_pkg::VALUE_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

>>> design/bobl_rsp_if.sv
// Response channel of the bounded ordered byte list: valid, ready and payload.
// Depends on bobl_pkg for the field widths.
interface bobl_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [bobl_pkg::STATUS_W-1:0]       status;
  logic signed [bobl_pkg::VALUE_W-1:0] removed_value;
  logic [bobl_pkg::COUNT_W-1:0]        entry_count;

  modport source (output valid, output status, output removed_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input removed_value, input entry_count,
                output ready);
endinterface

>>> design/bounded_ordered_byte_list_top.sv
// Bounded ordered byte list, top level; one request is worked at a time.
// A rejected, empty-list or unused request goes straight to the response, an append
// straight to the tail write; ordered insert, prepend and both deletes first run a pass
// over the entries. The next request is taken only after the response is loaded; the
// pass, one entry per cycle, sets the rate while the response register is free.
// Reset (rst, synchronous) empties the list; the entry memory is not cleared.
module bounded_ordered_byte_list_top #(
  parameter int CAPACITY = bobl_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  bobl_req_if.sink   req,
  bobl_rsp_if.source rsp
);
  import bobl_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  // The controller and the datapath talk only through these two bundles.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns the request handshake: a word is taken only when no
  // request is in progress, while a finished response may still wait in the
  // datapath's output register for the sink to take it.
  bobl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the entries in a RAM and runs at most one forward pass
  // per request. An insert carries each displaced entry one place back; a delete
  // moves each later entry one place forward. The final write of an insert and
  // the count update happen in the tail step.
  bobl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .req_kind          (req.kind),
    .req_value         (req.value),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_removed_value (rsp.removed_value),
    .rsp_entry_count   (rsp.entry_count)
  );

  // Only one request is in progress: the port closes right after a word is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in progress");

  // A full rejection reports the list at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_FULL) |-> rsp.entry_count == CAP_COUNT)
    else $error("full status with a count below capacity");

  // An empty report leaves the list empty.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_EMPTY) |-> rsp.entry_count == '0)
    else $error("empty status with a nonzero count");

  // Nothing is removed when the value was not found.
  a_not_found_removed: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_NOT_FOUND) |-> rsp.removed_value == '0)
    else $error("removed value reported for a missed delete");
endmodule

>>> design/bobl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bobl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> design/bobl_ctrl.sv
// Controller of the bounded ordered byte list: sequences accept, pass, tail and reply.
// Depends on bobl_pkg for the command and status bundles.
module bobl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bobl_pkg::dp_stat_t stat,
  output bobl_pkg::dp_cmd_t  cmd
);
  import bobl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PASS, S_TAIL, S_REPLY} state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          if (stat.early) begin
            state_next = S_REPLY;
          end else if (stat.direct_tail) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_PASS;
          end
        end
      end
      S_PASS: begin
        cmd.step = 1'b1;
        if (stat.pass_done) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);
endmodule

>>> design/bobl_dp.sv
// Datapath of the bounded ordered byte list: entry memory, fill count, the forward
// pass that shifts entries, and the response register. Depends on bobl_pkg and bobl_ram.
module bobl_dp #(
  parameter int CAPACITY = bobl_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bobl_pkg::dp_cmd_t                   cmd,
  output bobl_pkg::dp_stat_t                  stat,
  input  logic [bobl_pkg::KIND_W-1:0]         req_kind,
  input  logic signed [bobl_pkg::VALUE_W-1:0] req_value,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [bobl_pkg::STATUS_W-1:0]       rsp_status,
  output logic signed [bobl_pkg::VALUE_W-1:0] rsp_removed_value,
  output logic [bobl_pkg::COUNT_W-1:0]        rsp_entry_count
);
  import bobl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + COUNT_W;

  logic [CW-1:0]       count;
  logic [KIND_W-1:0]   kind_r;
  logic [VALUE_W-1:0]  value_r;
  logic [CW-1:0]       rp;
  logic [AW-1:0]       pp;
  logic                dv;
  logic                found;
  logic [VALUE_W-1:0]  carry;
  logic [VALUE_W-1:0]  removed_r;
  logic [STATUS_W-1:0] status_r;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [VALUE_W-1:0]  ram_rdata;

  logic                full;
  logic                empty;
  logic [STATUS_W-1:0] early_status;
  logic                del_mode;
  logic                hit;
  logic [EW-1:0]       count_ext;

  bobl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rp[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign del_mode  = kind_is_delete(kind_r);
  assign count_ext = EW'(count);

  // An insert matches at the first entry not smaller than the value; a delete
  // matches at the first equal entry, or at once when it removes the head.
  assign hit = del_mode ? ((kind_r == KIND_DEL_HEAD) || (ram_rdata == value_r))
                        : ($signed(value_r) <= $signed(ram_rdata));

  always_comb begin
    early_status = ST_DONE;
    stat.early   = 1'b0;
    if (kind_is_insert(req_kind)) begin
      if (full) begin
        early_status = ST_FULL;
        stat.early   = 1'b1;
      end
    end else if (kind_is_delete(req_kind)) begin
      if (empty) begin
        early_status = ST_EMPTY;
        stat.early   = 1'b1;
      end
    end else begin
      stat.early = 1'b1;
    end
    stat.direct_tail = (req_kind == KIND_APPEND);
    stat.pass_done   = (rp == count) && !dv;
    stat.out_free    = !rsp_valid || rsp_ready;
  end

  always_comb begin
    ram_re    = cmd.step && (rp < count);
    ram_we    = 1'b0;
    ram_waddr = pp;
    ram_wdata = ram_rdata;
    if (cmd.step && dv) begin
      if (!del_mode) begin
        // Insert: from the match on, each entry moves one place back.
        if (found || hit) begin
          ram_we    = 1'b1;
          ram_waddr = pp;
          ram_wdata = found ? carry : value_r;
        end
      end else if (found) begin
        // Delete: after the match, each entry moves one place forward.
        ram_we    = 1'b1;
        ram_waddr = pp - AW'(1);
        ram_wdata = ram_rdata;
      end
    end
    if (cmd.tail && !del_mode) begin
      ram_we    = 1'b1;
      ram_waddr = count[AW-1:0];
      ram_wdata = found ? carry : value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dv        <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        kind_r    <= req_kind;
        value_r   <= req_value;
        rp        <= '0;
        dv        <= 1'b0;
        found     <= (req_kind == KIND_PREPEND);
        carry     <= req_value;
        removed_r <= '0;
        status_r  <= early_status;
      end
      if (cmd.step) begin
        dv <= ram_re;
        if (ram_re) begin
          rp <= rp + 1'b1;
          pp <= rp[AW-1:0];
        end
        if (dv) begin
          if (!del_mode) begin
            if (found || hit) begin
              found <= 1'b1;
              carry <= ram_rdata;
            end
          end else if (!found && hit) begin
            found     <= 1'b1;
            removed_r <= ram_rdata;
          end
        end
      end
      if (cmd.tail) begin
        if (!del_mode) begin
          count <= count + 1'b1;
        end else if (found) begin
          count <= count - 1'b1;
        end else begin
          status_r <= ST_NOT_FOUND;
        end
      end
      if (cmd.finish) begin
        rsp_valid         <= 1'b1;
        rsp_status        <= status_r;
        rsp_removed_value <= $signed(removed_r);
        rsp_entry_count   <= count_ext[COUNT_W-1:0];
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end
endmodule

>>> tb/bobl_list_checker.sv
// Scoreboard for the bounded ordered byte list: watches both channels, keeps a
// shadow copy of the list and compares every response word with its prediction.
// Depends on bobl_pkg and on the bobl_req_if and bobl_rsp_if interfaces.
`timescale 1ns / 100ps

module bobl_list_checker #(
  parameter int CAPACITY = bobl_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  bobl_req_if  req,
  bobl_rsp_if  rsp,
  output int   fail_count,
  output int   outstanding
);
  import bobl_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        entry_count;
  } rsp_word_t;

  logic signed [VALUE_W-1:0] shadow_bytes [CAPACITY];
  int                        shadow_len = 0;
  rsp_word_t                 pending_rsps [$];

  initial fail_count = 0;
  initial outstanding = 0;

  // Pull the entry at pos out of the shadow list and close the gap.
  function automatic logic signed [VALUE_W-1:0] take_byte(input int pos);
    logic signed [VALUE_W-1:0] b;
    b = shadow_bytes[pos];
    for (int i = pos; i + 1 < shadow_len; i++) shadow_bytes[i] = shadow_bytes[i + 1];
    shadow_len--;
    return b;
  endfunction

  // Apply one request to the shadow list and return the response it must produce.
  function automatic rsp_word_t apply_request(input logic [KIND_W-1:0] kind,
                                              input logic signed [VALUE_W-1:0] value);
    rsp_word_t w;
    int        pos;
    w.status        = ST_DONE;
    w.removed_value = '0;
    case (kind)
      KIND_ORDERED, KIND_APPEND, KIND_PREPEND: begin
        if (shadow_len >= CAPACITY) begin
          w.status = ST_FULL;
        end else begin
          pos = 0;
          if (kind == KIND_ORDERED) begin
            while (pos < shadow_len && value > shadow_bytes[pos]) pos++;
          end else if (kind == KIND_APPEND) begin
            pos = shadow_len;
          end
          for (int i = shadow_len; i > pos; i--) shadow_bytes[i] = shadow_bytes[i - 1];
          shadow_bytes[pos] = value;
          shadow_len++;
        end
      end
      KIND_DEL_VALUE: begin
        if (shadow_len == 0) begin
          w.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < shadow_len && shadow_bytes[pos] != value) pos++;
          if (pos < shadow_len) w.removed_value = take_byte(pos);
          else w.status = ST_NOT_FOUND;
        end
      end
      KIND_DEL_HEAD: begin
        if (shadow_len == 0) w.status = ST_EMPTY;
        else w.removed_value = take_byte(0);
      end
      default: ;
    endcase
    w.entry_count = COUNT_W'(shadow_len);
    return w;
  endfunction

  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      shadow_len = 0;
      pending_rsps.delete();
    end else begin
      if (req.valid && req.ready) pending_rsps.push_back(apply_request(req.kind, req.value));
      if (rsp.valid && rsp.ready) begin
        if (pending_rsps.size() == 0) begin
          $error("response word with no request waiting: status %0d removed %0d count %0d",
                 rsp.status, rsp.removed_value, rsp.entry_count);
          fail_count++;
        end else begin
          want = pending_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, actual %0d",
                   want.removed_value, rsp.removed_value);
            fail_count++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, rsp.entry_count);
            fail_count++;
          end
        end
      end
    end
    outstanding <= pending_rsps.size();
  end

endmodule

>>> tb/bounded_ordered_byte_list_top_tb.sv
// Testbench top for the bounded ordered byte list: clock, reset, request
// stimulus, response back-pressure and the verdict. Prediction lives in
// bobl_list_checker; depends on bobl_pkg and the two channel interfaces.
`timescale 1ns / 100ps

module bounded_ordered_byte_list_top_tb;
  import bobl_pkg::*;

  // Generous cycle budget: even with heavy idling on both sides, the two
  // thousand or so words of a run fit many times over.
  localparam int CYCLE_LIMIT   = 800000;
  localparam int WORDS_PER_RUN = 490;  // random words in each idling phase
  localparam int TREND_LEN     = 40;   // words per fill or drain stretch
  localparam int DRAIN_CYCLES  = 40;   // quiet time after the last response

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int   sender_idle_pct = 0;
  int   rsp_stall_pct = 0;
  int   fail_count;
  int   outstanding;

  bobl_req_if req_ch ();
  bobl_rsp_if rsp_ch ();

  bounded_ordered_byte_list_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bobl_list_checker #(.CAPACITY(CAPACITY_DEF)) scoreboard (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs or loses a word.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL bounded_ordered_byte_list_top");
      $finish;
    end
  end

  // The response side stalls at random with the rate of the current phase.
  // Ready is redrawn every cycle. The block's pass over the entries does not
  // look at it, so stalls act only through the response register.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Offer one request word and hold it until the block takes it. Idle cycles
  // in front of the word come from the sender's idle rate. The task returns
  // at the edge that accepted the word, so the caller may raise valid again
  // for the next word in the same step without first lowering it.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic signed [VALUE_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // One random word. While filling, most words are inserts so the list
  // reaches capacity and the full rejection gets exercised; while draining,
  // most are deletes so the list runs dry and the empty case comes up. Values
  // mostly come from a narrow window so that delete-by-value finds its target
  // and ordered inserts meet equal entries; the rest span the whole byte.
  task automatic send_random_word(input bit filling);
    int                        roll;
    bit                        pick_insert;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    roll = $urandom_range(99);
    pick_insert = filling ? (roll < 80) : (roll >= 80);
    if (roll < 3) begin
      kind = KIND_W'($urandom_range(2 ** KIND_W - 1, KIND_DEL_HEAD + 1));
    end else if (pick_insert) begin
      case ($urandom_range(2))
        0:       kind = KIND_ORDERED;
        1:       kind = KIND_APPEND;
        default: kind = KIND_PREPEND;
      endcase
    end else begin
      kind = ($urandom_range(2) == 0) ? KIND_DEL_HEAD : KIND_DEL_VALUE;
    end
    roll = $urandom_range(99);
    if (roll < 60) begin
      value = VALUE_W'(int'($urandom_range(7)) - 4);
    end else if (roll < 80) begin
      case ($urandom_range(3))
        0:       value = 8'sh80;
        1:       value = 8'sh7f;
        2:       value = 8'shff;
        default: value = 8'sh00;
      endcase
    end else begin
      value = VALUE_W'($urandom_range(255));
    end
    send_word(kind, value);
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.kind  <= KIND_ORDERED;
    req_ch.value <= '0;
    rst          <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, no idling. Deletes on the empty list come first,
    // then the unused kinds, which must leave the list untouched.
    send_word(KIND_DEL_HEAD, 8'sh00);
    send_word(KIND_DEL_VALUE, 8'sh7f);
    for (int k = KIND_DEL_HEAD + 1; k < 2 ** KIND_W; k++) send_word(KIND_W'(k), 8'sh55);

    // Ordered inserts at both byte extremes and around zero, with a
    // duplicate of the largest value to check that equal entries go in
    // front. Append and prepend add further duplicates at the ends.
    send_word(KIND_ORDERED, 8'sh00);
    send_word(KIND_ORDERED, 8'sh7f);
    send_word(KIND_ORDERED, 8'sh80);
    send_word(KIND_ORDERED, 8'shff);
    send_word(KIND_ORDERED, 8'sh7f);
    send_word(KIND_APPEND, 8'sh80);
    send_word(KIND_PREPEND, 8'sh7f);

    // A value that is absent, then one present several times (only the
    // first copy goes), then the head.
    send_word(KIND_DEL_VALUE, 8'sh63);
    send_word(KIND_DEL_VALUE, 8'sh7f);
    send_word(KIND_DEL_HEAD, 8'sh00);

    // Fill the list to capacity with spread-out values, then try one more
    // insert, which must be turned away as full.
    for (int i = 0; i < 11; i++) send_word(KIND_ORDERED, VALUE_W'(i * 23 - 115));
    send_word(KIND_APPEND, 8'sh2a);

    // Random words in four idling phases: none, sender idle, receiver
    // stalling, and both at a lighter rate. Each phase alternates fill and
    // drain stretches so the list keeps swinging between empty and full.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
        1:       begin sender_idle_pct = 63; rsp_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  rsp_stall_pct = 63; end
        default: begin sender_idle_pct = 24; rsp_stall_pct = 24; end
      endcase
      for (int n = 0; n < WORDS_PER_RUN; n++) send_random_word(((n / TREND_LEN) % 2) == 0);
    end
    req_ch.valid <= 1'b0;

    // The checker counts the last word only after the edge that took it, so
    // step past that edge before waiting on the count of open responses.
    @(posedge clk);

    // Let every expected response arrive, then watch a little longer for
    // any stray word the block might still emit.
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS bounded_ordered_byte_list_top");
    end else begin
      $display("FAIL bounded_ordered_byte_list_top");
    end
    $finish;
  end

endmodule

>>> sim.f
design/bobl_pkg.sv
design/bobl_req_if.sv
design/bobl_rsp_if.sv
design/bobl_ram.sv
design/bobl_ctrl.sv
design/bobl_dp.sv
design/bounded_ordered_byte_list_top.sv
tb/bobl_list_checker.sv
tb/bounded_ordered_byte_list_top_tb.sv
